// ===== rtl/lrsfa_pkg.sv =====
package lrsfa_pkg;

	localparam int MaxLeds = 64;
	localparam int IdxW    = $clog2(MaxLeds);

	localparam logic [2:0] REG_INTERVAL  = 3'd0;
	localparam logic [2:0] REG_FADE_STEP = 3'd1;
	localparam logic [2:0] REG_SWEEP     = 3'd2;
	localparam logic [2:0] REG_LPR       = 3'd3;
	localparam logic [2:0] REG_ROWS      = 3'd4;

	localparam logic [31:0] RST_INTERVAL  = 32'd50;
	localparam logic [7:0]  RST_FADE_STEP = 8'd10;
	localparam logic        RST_SWEEP     = 1'b1;
	localparam logic [6:0]  RST_LPR       = 7'd8;
	localparam logic [6:0]  RST_ROWS      = 7'd8;

	localparam logic [7:0] LIT_GREEN = 8'd255;
	localparam logic [7:0] LIT_BLUE  = 8'd120;
	localparam logic [2:0] HOLD_SET  = 3'd5;

	// rows that fit into the store for a given row length (64 / lpr)
	function automatic logic [6:0] max_rows(input logic [6:0] lpr);
		logic [6:0] r;
		case (lpr) inside
			7'd1:              r = 7'd64;
			7'd2:              r = 7'd32;
			7'd3:              r = 7'd21;
			7'd4:              r = 7'd16;
			7'd5:              r = 7'd12;
			7'd6:              r = 7'd10;
			7'd7:              r = 7'd9;
			7'd8:              r = 7'd8;
			7'd9:              r = 7'd7;
			7'd10:             r = 7'd6;
			[7'd11:7'd12]:     r = 7'd5;
			[7'd13:7'd16]:     r = 7'd4;
			[7'd17:7'd21]:     r = 7'd3;
			[7'd22:7'd32]:     r = 7'd2;
			[7'd33:7'd64]:     r = 7'd1;
			default:           r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : 8'd0;
	endfunction

endpackage

// ===== rtl/led_row_sweep_fade_animator_core.sv =====
// Steps: a refresh passes ST_ROWS, ST_STEP and ST_START, then for each LED through the frame store
//   reads (ST_RD), then fades/lights, writes back and loads the output register (ST_PROC).
// An input that does not refresh is only taken; an empty section returns to idle from ST_STEP.
// One input at a time; tready is low while a refresh walks the store.
// Reset: registers to defaults, store reads as zero via per-entry valid bits,
//   timers, hold and row pointer to zero.
module led_row_sweep_fade_animator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [5:0] led_index, [13:6] green_level, [21:14] blue_level
	output logic        m_axis_tlast    // frame_last
);
	import lrsfa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROWS,
		ST_STEP,
		ST_START,
		ST_RD,
		ST_PROC
	} state_t;

	state_t state_q;

	logic [31:0] interval_q;
	logic [7:0]  fade_step_q;
	logic        sweep_q;
	logic [6:0]  lpr_q;
	logic [6:0]  rows_cfg_q;

	logic [31:0]      last_q;
	logic [2:0]       hold_q;
	logic [IdxW-1:0]  row_q;
	logic [6:0]       rows_q;
	logic [6:0]       n_q;
	logic [6:0]       start_q;
	logic             lit_en_q;
	logic [IdxW-1:0]  i_q;
	logic [MaxLeds-1:0] vld_q;

	logic [15:0] mem [MaxLeds];
	logic [15:0] rd_q;
	logic        rd_vld_q;

	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_last_q;

	logic [2:0]  reg_idx;
	logic        cfg_wr;
	logic        in_xfer;
	logic [31:0] diff;
	logic        out_free;
	logic [7:0]  g_cur, b_cur, g_new, b_new;
	logic        in_lit;
	logic [7:0]  lit_end;
	logic [6:0]  nxt_row;
	logic [6:0]  row_ext;
	logic [13:0] n_prod;
	logic [13:0] start_prod;
	logic        wr_en;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_INTERVAL:  prdata = interval_q;
			REG_FADE_STEP: prdata = {24'd0, fade_step_q};
			REG_SWEEP:     prdata = {31'd0, sweep_q};
			REG_LPR:       prdata = {25'd0, lpr_q};
			REG_ROWS:      prdata = {25'd0, rows_cfg_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= RST_INTERVAL;
			fade_step_q <= RST_FADE_STEP;
			sweep_q     <= RST_SWEEP;
			lpr_q       <= RST_LPR;
			rows_cfg_q  <= RST_ROWS;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INTERVAL:  interval_q  <= pwdata;
				REG_FADE_STEP: fade_step_q <= pwdata[7:0];
				REG_SWEEP:     sweep_q     <= pwdata[0];
				REG_LPR:       lpr_q       <= pwdata[6:0];
				REG_ROWS:      rows_cfg_q  <= pwdata[6:0];
				default:       ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign diff          = s_axis_tdata - last_q;

	assign out_free = !out_valid_q || m_axis_tready;

	// row pointer step with wraparound
	assign row_ext = {1'b0, row_q};
	always_comb begin
		if (sweep_q) begin
			if (row_q == '0)
				nxt_row = rows_q - 7'd1;
			else if ((row_ext - 7'd1) >= rows_q)
				nxt_row = 7'd0;
			else
				nxt_row = row_ext - 7'd1;
		end else begin
			if ((row_ext + 7'd1) >= rows_q)
				nxt_row = 7'd0;
			else
				nxt_row = row_ext + 7'd1;
		end
	end

	assign n_prod     = rows_q * lpr_q;
	assign start_prod = row_ext * lpr_q;

	assign g_cur   = rd_vld_q ? rd_q[7:0]  : 8'd0;
	assign b_cur   = rd_vld_q ? rd_q[15:8] : 8'd0;
	assign lit_end = {1'b0, start_q} + {1'b0, lpr_q};
	assign in_lit  = lit_en_q && ({1'b0, i_q} >= start_q) && ({2'b0, i_q} < lit_end);
	assign g_new   = in_lit ? LIT_GREEN : sat_sub(g_cur, {fade_step_q[6:0], 1'b0});
	assign b_new   = in_lit ? LIT_BLUE  : sat_sub(b_cur, fade_step_q);
	assign wr_en   = (state_q == ST_PROC) && out_free;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[i_q] <= {b_new, g_new};
		if (state_q == ST_RD)
			rd_q <= mem[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			hold_q      <= '0;
			row_q       <= '0;
			rows_q      <= '0;
			n_q         <= '0;
			start_q     <= '0;
			vld_q       <= '0;
			lit_en_q    <= 1'b0;
			i_q         <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !wr_en)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (diff >= interval_q)) begin
						last_q  <= s_axis_tdata;
						state_q <= ST_ROWS;
					end
				end
				ST_ROWS: begin
					rows_q  <= (rows_cfg_q > max_rows(lpr_q)) ? max_rows(lpr_q) : rows_cfg_q;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					n_q <= n_prod[6:0];
					if (rows_q == 7'd0) begin
						state_q <= ST_IDLE;
					end else begin
						if (hold_q != 3'd0) begin
							hold_q   <= hold_q - 3'd1;
							lit_en_q <= 1'b0;
						end else begin
							row_q    <= nxt_row[IdxW-1:0];
							lit_en_q <= 1'b1;
							if ((sweep_q && nxt_row == 7'd0) ||
							    (!sweep_q && nxt_row == rows_q - 7'd1))
								hold_q <= HOLD_SET;
						end
						state_q <= ST_START;
					end
				end
				ST_START: begin
					start_q <= start_prod[6:0];
					i_q     <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					rd_vld_q <= vld_q[i_q];
					state_q  <= ST_PROC;
				end
				ST_PROC: begin
					if (out_free) begin
						vld_q[i_q]  <= 1'b1;
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b0, b_new, g_new, i_q};
						out_last_q  <= ({1'b0, i_q} == n_q - 7'd1);
						if ({1'b0, i_q} == n_q - 7'd1) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROC) |-> ({1'b0, i_q} < n_q))
		else $error("LED index beyond frame length");

	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HOLD_SET)
		else $error("hold counter out of range");

	a_out_from_proc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_PROC))
		else $error("result loaded outside the LED walk");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_PROC) |-> !s_axis_tready)
		else $error("input taken during a refresh");

endmodule
